// ===== hw/rtl/see_pkg.sv =====
// ---------------------------------------------------------------------------
// see_pkg - shared definitions for the segment endpoint extend block
// Operation, mode and status codes, default widths and the control and
// status groups of the shared multiply/divide unit.
// ---------------------------------------------------------------------------
package see_pkg;

    localparam int COORD_BITS_DEF = 24;

    localparam logic [1:0] OP_LOAD      = 2'd0;
    localparam logic [1:0] OP_EXT_POINT = 2'd1;
    localparam logic [1:0] OP_EXT_PLANE = 2'd2;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    localparam logic [2:0] MODE_END1    = 3'd0;
    localparam logic [2:0] MODE_END2    = 3'd1;
    localparam logic [2:0] MODE_NEARER  = 3'd2;
    localparam logic [2:0] MODE_BEYOND  = 3'd3;
    localparam logic [2:0] MODE_NEAR    = 3'd4;

    localparam logic [2:0] STAT_END1    = 3'd0;
    localparam logic [2:0] STAT_END2    = 3'd1;
    localparam logic [2:0] STAT_NOMOVE  = 3'd2;
    localparam logic [2:0] STAT_BADMODE = 3'd3;
    localparam logic [2:0] STAT_DEGEN   = 3'd4;
    localparam logic [2:0] STAT_LOADED  = 3'd5;

    typedef struct packed {
        logic start;
        logic is_div;    // 1: restoring divide, 0: shift-add multiply
        logic short_run; // multiply over the short operand width only
    } unit_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ===== hw/rtl/see_shared_unit.sv =====
// ---------------------------------------------------------------------------
// see_shared_unit - bit-serial unsigned multiply / divide
// One bit per cycle: shift-add multiply over SW or PW multiplier bits,
// restoring divide over PW numerator bits. Done pulses with the result.
// ---------------------------------------------------------------------------
module see_shared_unit
    import see_pkg::*;
#(
    parameter int PW = 79,
    parameter int SW = 25
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  unit_ctrl_t    ctrl,
    input  logic [PW-1:0] opa,
    input  logic [PW-1:0] opb,
    output unit_stat_t    stat,
    output logic [PW-1:0] result
);

    localparam int CW = $clog2(PW + 1);

    logic [PW-1:0] a_reg, a_next;
    logic [PW-1:0] b_reg, b_next;
    logic [PW-1:0] acc_reg, acc_next;
    logic [PW-1:0] rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          div_reg, div_next;
    logic          done_reg, done_next;
    logic [PW:0]   trial;
    logic [PW:0]   diff;

    always_comb
    begin
        trial = {rem_reg, a_reg[PW-1]};
        diff  = trial - {1'b0, b_reg};
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            a_next    = opa;
            b_next    = opb;
            acc_next  = '0;
            rem_next  = '0;
            div_next  = ctrl.is_div;
            cnt_next  = (ctrl.short_run && !ctrl.is_div) ? CW'(SW) : CW'(PW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                // remainder stays below the divisor, so PW bits hold it
                a_next = {a_reg[PW-2:0], 1'b0};
                if (!diff[PW])
                begin
                    rem_next = diff[PW-1:0];
                    acc_next = {acc_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[PW-1:0];
                    acc_next = {acc_reg[PW-2:0], 1'b0};
                end
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = {a_reg[PW-2:0], 1'b0};
                b_next = {1'b0, b_reg[PW-1:1]};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            div_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            div_reg  <= div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = acc_reg;

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !ctrl.start)
        else $error("unit started while busy");
    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("unit done while still busy");
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("unit busy with zero count");

endmodule

// ===== hw/rtl/segment_endpoint_extend.sv =====
// ---------------------------------------------------------------------------
// segment_endpoint_extend - move one endpoint of a 3D segment along its line
// Loads a segment, projects a point or intersects a plane, moves an end.
// ---------------------------------------------------------------------------
// One item at a time; s_tready is high only while idle. A load, an unused
// operation or a bad mode goes from idle straight to the output state. An extend
// item runs six serial multiplies of COORD_BITS+1 bit steps for the dot products,
// then per coordinate one multiply of COORD_BITS+1 steps and one divide of
// 3*COORD_BITS+7 steps, all on one bit-serial multiply/divide unit. Each
// multiply and divide passes through its start and wait states, each coordinate
// ends in the place state, and degenerate or no-move items stop after the dot
// products.
// Results are rounded half away from zero and saturate to the coordinate range.
module segment_endpoint_extend
    import see_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int TDW = ((6 * COORD_BITS + 7) / 8) * 8
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    // vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z
    input  logic [TDW-1:0] s_tdata,
    // operation[1:0], mode[4:2]
    input  logic [4:0]     s_tuser,
    output logic           m_tvalid,
    input  logic           m_tready,
    // end1_x, end1_y, end1_z, end2_x, end2_y, end2_z
    output logic [TDW-1:0] m_tdata,
    // status[2:0]
    output logic [2:0]     m_tuser
);

    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;
    localparam int W  = 2 * C + 4;
    localparam int PW = 3 * C + 7;
    localparam logic signed [PW:0] SAT_HI = (PW+1)'((64'sd1 <<< (C - 1)) - 64'sd1);
    localparam logic signed [PW:0] SAT_LO = -SAT_HI - (PW+1)'(1);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DOT_ST = 10'b0000000010,
        S_DOT_WT = 10'b0000000100,
        S_CHK    = 10'b0000001000,
        S_PM_ST  = 10'b0000010000,
        S_PM_WT  = 10'b0000100000,
        S_PD_ST  = 10'b0001000000,
        S_PD_WT  = 10'b0010000000,
        S_PLACE  = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } state_t;

    state_t                state_reg, state_next;
    logic signed [C-1:0]   e1_reg [3];
    logic signed [C-1:0]   e2_reg [3];
    logic signed [C-1:0]   va_reg [3];
    logic signed [C-1:0]   vb_reg [3];
    logic signed [C-1:0]   q_reg  [3];
    logic [1:0]            op_reg;
    logic [2:0]            mode_reg;
    logic [2:0]            stat_reg, stat_next;
    logic [2:0]            k_reg, k_next;
    logic signed [W-1:0]   num_reg, num_next;
    logic signed [W-1:0]   den_reg, den_next;
    logic                  neg_reg, neg_next;
    logic                  end2_reg, end2_next;
    logic [PW-1:0]         p_reg;

    unit_ctrl_t            uctrl;
    unit_stat_t            ustat;
    logic [PW-1:0]         uopa, uopb, ures;

    logic [1:0]            csel;
    logic signed [DW-1:0]  dsel, rel, mx, my;
    logic [DW-1:0]         amx, amy, adsel;
    logic signed [W-1:0]   prod_w;
    logic signed [W-1:0]   num_n, den_n, num_abs;
    logic signed [W+2:0]   five, four;
    logic signed [W:0]     twonum;
    logic signed [PW-1:0]  qs;
    logic signed [PW:0]    sum;
    logic signed [C-1:0]   qsat;
    logic                  dot_is_num;
    logic                  commit;

    see_shared_unit #(.PW(PW), .SW(DW)) u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (uctrl),
        .opa    (uopa),
        .opb    (uopb),
        .stat   (ustat),
        .result (ures)
    );

    assign csel       = (state_reg == S_DOT_ST || state_reg == S_DOT_WT) ? k_reg[2:1] : k_reg[1:0];
    assign dot_is_num = !k_reg[0];

    always_comb
    begin
        dsel = DW'(e2_reg[csel]) - DW'(e1_reg[csel]);
        rel  = DW'(va_reg[csel]) - DW'(e1_reg[csel]);
        if (dot_is_num)
        begin
            mx = (op_reg == OP_EXT_PLANE) ? DW'(vb_reg[csel]) : dsel;
            my = rel;
        end
        else
        begin
            mx = (op_reg == OP_EXT_PLANE) ? DW'(vb_reg[csel]) : dsel;
            my = dsel;
        end
        amx   = mx[DW-1] ? DW'(-mx) : DW'(mx);
        amy   = my[DW-1] ? DW'(-my) : DW'(my);
        adsel = dsel[DW-1] ? DW'(-dsel) : DW'(dsel);
        num_abs = num_reg[W-1] ? -num_reg : num_reg;
        prod_w  = neg_reg ? -$signed(ures[W-1:0]) : $signed(ures[W-1:0]);

        // sign-normalized pair for the threshold tests
        num_n  = den_reg[W-1] ? -num_reg : num_reg;
        den_n  = den_reg[W-1] ? -den_reg : den_reg;
        five   = ((W+3)'(num_n) <<< 2) + (W+3)'(num_n);
        four   = (W+3)'(den_n) <<< 2;
        twonum = (W+1)'(num_n) <<< 1;

        qs  = neg_reg ? -$signed(ures) : $signed(ures);
        sum = (PW+1)'(e1_reg[csel]) + (PW+1)'(qs);
        if (sum > SAT_HI)
        begin
            qsat = C'(SAT_HI);
        end
        else if (sum < SAT_LO)
        begin
            qsat = C'(SAT_LO);
        end
        else
        begin
            qsat = sum[C-1:0];
        end
    end

    always_comb
    begin
        uctrl = '0;
        uopa  = '0;
        uopb  = '0;
        case (state_reg)
            S_DOT_ST:
            begin
                uctrl.start     = 1'b1;
                uctrl.short_run = 1'b1;
                uopa            = PW'(amx);
                uopb            = PW'(amy);
            end
            S_PM_ST:
            begin
                // the endpoint always moves along the segment direction
                uctrl.start     = 1'b1;
                uctrl.short_run = 1'b1;
                uopa            = PW'($unsigned(num_abs));
                uopb            = PW'(adsel);
            end
            S_PD_ST:
            begin
                uctrl.start  = 1'b1;
                uctrl.is_div = 1'b1;
                uopa         = (p_reg << 1) + PW'($unsigned(den_reg));
                uopb         = PW'($unsigned(den_reg)) << 1;
            end
            default:
            begin
                uctrl = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        stat_next  = stat_reg;
        k_next     = k_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        end2_next  = end2_reg;
        commit     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_OUT;
                    if (s_tuser[1:0] == OP_LOAD)
                    begin
                        stat_next = STAT_LOADED;
                    end
                    else if (s_tuser[1:0] != OP_EXT_POINT && s_tuser[1:0] != OP_EXT_PLANE)
                    begin
                        stat_next = STAT_NOMOVE;
                    end
                    else if (s_tuser[4:2] > MODE_NEAR)
                    begin
                        stat_next = STAT_BADMODE;
                    end
                    else
                    begin
                        k_next     = '0;
                        num_next   = '0;
                        den_next   = '0;
                        state_next = S_DOT_ST;
                    end
                end
            end
            S_DOT_ST:
            begin
                neg_next   = mx[DW-1] ^ my[DW-1];
                state_next = S_DOT_WT;
            end
            S_DOT_WT:
            begin
                if (ustat.done)
                begin
                    if (dot_is_num)
                    begin
                        num_next = num_reg + prod_w;
                    end
                    else
                    begin
                        den_next = den_reg + prod_w;
                    end
                    k_next     = k_reg + 3'd1;
                    state_next = (k_reg == 3'd5) ? S_CHK : S_DOT_ST;
                end
            end
            S_CHK:
            begin
                num_next = num_n;
                den_next = den_n;
                k_next   = '0;
                state_next = S_PM_ST;
                if (den_reg == '0)
                begin
                    stat_next  = STAT_DEGEN;
                    state_next = S_OUT;
                end
                else
                begin
                    case (mode_reg)
                        MODE_END1:   end2_next = 1'b0;
                        MODE_END2:   end2_next = 1'b1;
                        MODE_NEARER: end2_next = !(twonum < (W+1)'(den_n));
                        MODE_BEYOND:
                        begin
                            end2_next = !num_n[W-1];
                            if (!num_n[W-1] && !(den_n < num_n))
                            begin
                                stat_next  = STAT_NOMOVE;
                                state_next = S_OUT;
                            end
                        end
                        default:
                        begin
                            end2_next = !(five < (W+3)'(den_n));
                            if (!(five < (W+3)'(den_n)) && !(four < five))
                            begin
                                stat_next  = STAT_NOMOVE;
                                state_next = S_OUT;
                            end
                        end
                    endcase
                end
            end
            S_PM_ST:
            begin
                neg_next   = dsel[DW-1] ^ num_reg[W-1];
                state_next = S_PM_WT;
            end
            S_PM_WT:
            begin
                if (ustat.done)
                begin
                    state_next = S_PD_ST;
                end
            end
            S_PD_ST:
            begin
                state_next = S_PD_WT;
            end
            S_PD_WT:
            begin
                if (ustat.done)
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd2)
                begin
                    commit     = 1'b1;
                    stat_next  = end2_reg ? STAT_END2 : STAT_END1;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_PM_ST;
                end
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stat_reg  <= STAT_NOMOVE;
            k_reg     <= '0;
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= '0;
                e2_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
            k_reg     <= k_next;
            if (state_reg == S_IDLE && s_tvalid && s_tuser[1:0] == OP_LOAD)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    e1_reg[i] <= s_tdata[i*C +: C];
                    e2_reg[i] <= s_tdata[(i+3)*C +: C];
                end
            end
            if (commit)
            begin
                for (int i = 0; i < 2; i++)
                begin
                    if (end2_reg)
                    begin
                        e2_reg[i] <= q_reg[i];
                    end
                    else
                    begin
                        e1_reg[i] <= q_reg[i];
                    end
                end
                if (end2_reg)
                begin
                    e2_reg[2] <= qsat;
                end
                else
                begin
                    e1_reg[2] <= qsat;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        end2_reg <= end2_next;
        if (state_reg == S_IDLE && s_tvalid)
        begin
            op_reg   <= s_tuser[1:0];
            mode_reg <= s_tuser[4:2];
            for (int i = 0; i < 3; i++)
            begin
                va_reg[i] <= s_tdata[i*C +: C];
                vb_reg[i] <= s_tdata[(i+3)*C +: C];
            end
        end
        if (state_reg == S_PM_WT && ustat.done)
        begin
            p_reg <= ures;
        end
        if (state_reg == S_PLACE)
        begin
            q_reg[k_reg[1:0]] <= qsat;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tuser  = stat_reg;
    assign m_tdata  = TDW'({e2_reg[2], e2_reg[1], e2_reg[0], e1_reg[2], e1_reg[1], e1_reg[0]});

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result waits");
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ustat.done |-> (state_reg == S_DOT_WT || state_reg == S_PM_WT || state_reg == S_PD_WT))
        else $error("unit result outside a wait state");
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[1:0] == OP_LOAD) |=> (m_tvalid && m_tuser == STAT_LOADED))
        else $error("load did not answer next cycle");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= STAT_LOADED))
        else $error("status code out of range");

endmodule

// ===== bench/tb.sv =====
// ---------------------------------------------------------------------------
// tb - testbench for segment_endpoint_extend
// Drives load, extend-to-point, extend-to-plane and unused-operation items with random idling,
// predicts endpoints and status with exact wide integer math, checks each item.
// ---------------------------------------------------------------------------
module tb
    import see_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = 24;
    localparam int TDW = 144;
    localparam longint CMAX = 64'sd8388607;
    localparam longint CMIN = -64'sd8388608;

    typedef struct packed {
        logic [2:0]  status;
        logic [TDW-1:0] ends;
    } seg_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [TDW-1:0] s_tdata = '0;
    logic [4:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [TDW-1:0] m_tdata;
    logic [2:0] m_tuser;

    segment_endpoint_extend i_dut (.*);

    always #10 clk = ~clk;

    // segment state of the predictor
    longint seg_p1 [3];
    longint seg_p2 [3];
    seg_out_t pending_ends [$];
    int errors = 0;
    longint unsigned cycles = 0;
    bit hold_off = 1'b0;
    bit no_idle = 1'b0;

    always @(posedge clk) cycles <= cycles + 1;

    task automatic report(input string what);
        errors++;
        $display("error @%0t: %s", $realtime, what);
    endtask

    function automatic logic signed [127:0] round_div(input logic signed [127:0] p,
                                                      input logic signed [127:0] den);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        mag = p < 0 ? -p : p;
        q = (2 * mag + den) / (2 * den);
        return p < 0 ? -q : q;
    endfunction

    function automatic longint clamp(input logic signed [127:0] v);
        if (v > CMAX) return CMAX;
        if (v < CMIN) return CMIN;
        return longint'(v);
    endfunction

    function automatic seg_out_t predict_segment(input logic [1:0] op, input logic [2:0] md,
                                                 input longint va [3], input longint vb [3]);
        seg_out_t r;
        logic signed [127:0] num, den, dd, rel;
        longint q [3];
        int which;
        r.status = STAT_NOMOVE;
        if (op == OP_LOAD)
        begin
            for (int c = 0; c < 3; c++)
            begin
                seg_p1[c] = va[c];
                seg_p2[c] = vb[c];
            end
            r.status = STAT_LOADED;
        end
        else if (op == OP_EXT_POINT || op == OP_EXT_PLANE)
        begin
            if (md > MODE_NEAR) r.status = STAT_BADMODE;
            else
            begin
                num = 0;
                den = 0;
                for (int c = 0; c < 3; c++)
                begin
                    dd = seg_p2[c] - seg_p1[c];
                    rel = va[c] - seg_p1[c];
                    if (op == OP_EXT_POINT)
                    begin
                        num += dd * rel;
                        den += dd * dd;
                    end
                    else
                    begin
                        num += vb[c] * rel;
                        den += vb[c] * dd;
                    end
                end
                if (den == 0) r.status = STAT_DEGEN;
                else
                begin
                    if (den < 0)
                    begin
                        den = -den;
                        num = -num;
                    end
                    which = -1;
                    case (md)
                        MODE_END1: which = 0;
                        MODE_END2: which = 1;
                        MODE_NEARER: which = (2 * num < den) ? 0 : 1;
                        MODE_BEYOND: which = num < 0 ? 0 : (den < num ? 1 : -1);
                        default: which = (5 * num < den) ? 0 : ((4 * den < 5 * num) ? 1 : -1);
                    endcase
                    if (which >= 0)
                    begin
                        for (int c = 0; c < 3; c++)
                        begin
                            dd = seg_p2[c] - seg_p1[c];
                            q[c] = clamp(seg_p1[c] + round_div(dd * num, den));
                        end
                        for (int c = 0; c < 3; c++)
                            if (which == 0) seg_p1[c] = q[c];
                            else seg_p2[c] = q[c];
                        r.status = which == 0 ? STAT_END1 : STAT_END2;
                    end
                end
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            r.ends[c*CB +: CB] = seg_p1[c][CB-1:0];
            r.ends[(3+c)*CB +: CB] = seg_p2[c][CB-1:0];
        end
        return r;
    endfunction

    // valid stays up after an accepted item; it drops on an idle gap or a drain
    task automatic send_item(input logic [1:0] op, input logic [2:0] md,
                             input longint va [3], input longint vb [3]);
        logic [TDW-1:0] d;
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        d = '0;
        for (int c = 0; c < 3; c++)
        begin
            d[c*CB +: CB] = va[c][CB-1:0];
            d[(3+c)*CB +: CB] = vb[c][CB-1:0];
        end
        s_tdata <= d;
        s_tuser <= {md, op};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        pending_ends.push_back(predict_segment(op, md, va, vb));
        @(negedge clk);
    endtask

    // receiver readiness: a drawn wait before each result, or a long hold-off
    initial
    begin
        int rx_gap;
        forever
        begin
            rx_gap = no_idle ? 0 : $urandom_range(0, 8);
            while (hold_off || rx_gap != 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                if (!hold_off && rx_gap != 0)
                    rx_gap--;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        seg_out_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_ends.size() == 0) report("result with nothing expected");
            else
            begin
                e = pending_ends.pop_front();
                if (m_tuser !== e.status)
                    report($sformatf("status got %0d exp %0d", m_tuser, e.status));
                for (int f = 0; f < 6; f++)
                    if (m_tdata[f*CB +: CB] !== e.ends[f*CB +: CB])
                        report($sformatf("coord %0d got %h exp %h", f,
                                         m_tdata[f*CB +: CB], e.ends[f*CB +: CB]));
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > 64'd3000000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic longint rnd_coord(input int spread);
        case ($urandom_range(0, 9))
            0: return CMAX;
            1: return CMIN;
            default: return longint'($urandom_range(0, 2 * spread)) - spread;
        endcase
    endfunction

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_ends.size() != 0) @(negedge clk);
    endtask

    task automatic test_directed();
        longint a [3], b [3], z [3];
        z = '{0, 0, 0};
        a = '{0, 0, 0}; b = '{2560, 0, 0};
        send_item(OP_LOAD, MODE_END1, a, b);
        a = '{3840, 100, -50};
        send_item(OP_EXT_POINT, MODE_END2, a, z);
        send_item(OP_EXT_POINT, MODE_END1, '{-512, 7, 7}, z);
        send_item(OP_EXT_POINT, MODE_NEARER, '{1000, 0, 0}, z);
        send_item(OP_EXT_POINT, MODE_NEARER, '{3000, 0, 0}, z);
        send_item(OP_EXT_POINT, MODE_BEYOND, '{1000, 0, 0}, z);
        send_item(OP_EXT_POINT, MODE_BEYOND, '{-900, 0, 0}, z);
        send_item(OP_EXT_POINT, MODE_NEAR, '{1700, 0, 0}, z);
        send_item(OP_EXT_POINT, MODE_NEAR, '{-100, 0, 0}, z);
        for (int m = 5; m < 8; m++) send_item(OP_EXT_PLANE, 3'(m), a, b);
        send_item(OP_EXT_PLANE, MODE_END2, '{5000, 0, 0}, '{256, 0, 0});
        send_item(OP_EXT_PLANE, MODE_END1, a, '{0, 256, 0}); // parallel plane
        send_item(OP_EXT_PLANE, MODE_END1, a, z);             // zero normal
        send_item(OP_UNUSED, MODE_END1, a, b);
        // saturating extremes
        send_item(OP_LOAD, MODE_END1, '{CMIN, CMIN, CMAX}, '{CMAX, CMAX, CMIN});
        send_item(OP_EXT_POINT, MODE_END2, '{CMAX, CMAX, CMAX}, z);
        send_item(OP_LOAD, MODE_END1, '{CMAX, 0, 0}, '{CMAX - 1, 1, -1});
        send_item(OP_EXT_POINT, MODE_END2, '{CMIN, CMIN, CMAX}, z);
        send_item(OP_LOAD, MODE_END1, a, a);                  // zero length
        send_item(OP_EXT_POINT, MODE_NEARER, b, z);
        wait_drain();
    endtask

    task automatic test_random(input int n);
        longint a [3], b [3];
        logic [1:0] op;
        int sp;
        for (int i = 0; i < n; i++)
        begin
            sp = ($urandom_range(0, 3) == 0) ? 8388607 : 20000;
            for (int c = 0; c < 3; c++)
            begin
                a[c] = rnd_coord(sp);
                b[c] = rnd_coord(sp);
            end
            case ($urandom_range(0, 9))
                0, 1: op = OP_LOAD;
                2, 3, 4, 5: op = OP_EXT_POINT;
                6, 7, 8: op = OP_EXT_PLANE;
                default: op = 2'($urandom_range(0, 3));
            endcase
            send_item(op, ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                      : 3'($urandom_range(0, 4)), a, b);
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(negedge clk);
                hold_off = 1'b0;
            end
            test_random(8);
        join
        wait_drain();
        no_idle = 1'b1;
        test_random(30);
        no_idle = 1'b0;
        wait_drain();
    endtask

    initial
    begin
        for (int c = 0; c < 3; c++)
        begin
            seg_p1[c] = 0;
            seg_p2[c] = 0;
        end
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_backpressure();
        test_random(600);
        wait_drain();
        repeat (600) @(negedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
